// ----- hw/rtl/sil_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insert list package
// Shared sizes and the request type passed from the front end to the back end.
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned IDX_W      = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned POS_W      = 5;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     start_new;
  } req_t;

endpackage

// ----- hw/rtl/sorted_insert_list_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insert list
// Keeps an ascending list of signed 32-bit values and streams the whole list
// after every request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry value_i and start_new_i.
//   A request is taken when in_valid_i is high and in_stall_o is low.
//   start_new_i = 1 empties the list before the value goes in.
//   Output channel: out_valid_o / out_stall_i carry one entry per transfer:
//   element_o, its position_o, last_o on the final entry, and dropped_o on
//   every entry of a run where the list was already full (value discarded).
//   With the back end idle, a taken request passes the queue slot, the run
//   context and the output register before its first entry is valid.
//   Each request takes one pop in the back end, then one list walk through
//   the storage with one read and (unless the value is dropped) one write
//   per entry, one entry per cycle while out_stall_i does not hold the output
//   register; the next request is popped only once the walk has finished.
//   A two-entry request queue lets the input side keep going while a walk
//   is under way; in_stall_o rises only when that queue is full.
//   When out_stall_i is high the walk pauses on the current entry and resumes
//   as soon as the output register drains; nothing is lost or repeated.
//   Reset empties the list and the queue; storage contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_insert_list_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [sil_pkg::DATA_W-1:0] value_i,
  input  logic                              start_new_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [sil_pkg::DATA_W-1:0] element_o,
  output logic        [sil_pkg::POS_W-1:0]  position_o,
  output logic                              last_o,
  output logic                              dropped_o
);

  sil_pkg::req_t in_req;
  sil_pkg::req_t q_req;
  logic          q_valid;
  logic          q_pop;

  assign in_req.value     = value_i;
  assign in_req.start_new = start_new_i;

  // front end: request intake and queue
  sil_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_req_o    (q_req)
  );

  // back end: list walk with in-flight insertion
  sil_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_req_i     (q_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .element_o   (element_o),
    .position_o  (position_o),
    .last_o      (last_o),
    .dropped_o   (dropped_o)
  );

endmodule

// ----- hw/rtl/sil_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insert list front end
// Accepts requests and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sil_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sil_pkg::req_t in_req_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output sil_pkg::req_t q_req_o
);

  sil_pkg::req_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    fill_q, fill_d;
  logic          push, pop;

  assign in_stall_o = (fill_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (fill_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_req_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_req_i;
    end
  end

endmodule

// ----- hw/rtl/sil_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insert list back end
// Walks the stored list once per request, inserting the new value on the fly
// and streaming every entry through the output register.
// ----------------------------------------------------------------------------
module sil_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  output logic                                q_pop_o,
  input  sil_pkg::req_t                       q_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sil_pkg::DATA_W-1:0]   element_o,
  output logic        [sil_pkg::POS_W-1:0]    position_o,
  output logic                                last_o,
  output logic                                dropped_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                            state_q;
  logic        [sil_pkg::CNT_W-1:0]  count_q;
  logic        [sil_pkg::CNT_W-1:0]  n_q;
  logic        [sil_pkg::CNT_W-1:0]  total_q;
  logic        [sil_pkg::IDX_W-1:0]  idx_q;
  logic signed [sil_pkg::DATA_W-1:0] v_q;
  logic signed [sil_pkg::DATA_W-1:0] carry_q;
  logic                              drop_q;
  logic                              ins_q;

  // list storage: one write and one registered read per cycle
  logic signed [sil_pkg::DATA_W-1:0] mem_q [sil_pkg::LIST_DEPTH];
  logic signed [sil_pkg::DATA_W-1:0] rdata_q;
  logic                              rd_en;
  logic        [sil_pkg::IDX_W-1:0]  rd_addr;
  logic                              wr_en;

  logic                              out_free;
  logic                              step;
  logic                              ins_now;
  logic signed [sil_pkg::DATA_W-1:0] elem;
  logic        [sil_pkg::CNT_W-1:0]  idx_nxt;
  logic                              at_end;
  logic        [sil_pkg::CNT_W-1:0]  n_new;
  logic                              drop_new;

  assign out_free = !out_valid_o || !out_stall_i;
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign step     = (state_q == ST_RUN) && out_free;

  assign n_new    = q_req_i.start_new ? '0 : count_q;
  assign drop_new = (n_new == sil_pkg::CNT_W'(sil_pkg::LIST_DEPTH));

  // insertion point: first old entry not below the value, or the list end
  assign ins_now  = !drop_q && !ins_q &&
                    ((sil_pkg::CNT_W'(idx_q) == n_q) || (rdata_q >= v_q));
  assign idx_nxt  = sil_pkg::CNT_W'(idx_q) + sil_pkg::CNT_W'(1);
  assign at_end   = (idx_nxt == total_q);

  always_comb begin
    if (ins_now) begin
      elem = v_q;
    end else if (ins_q) begin
      elem = carry_q;
    end else begin
      elem = rdata_q;
    end
  end

  assign wr_en = step && !drop_q;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (q_pop_o) begin
      rd_en = 1'b1;
    end else if (step && !at_end) begin
      rd_en   = 1'b1;
      rd_addr = sil_pkg::IDX_W'(idx_nxt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[idx_q] <= elem;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_o <= step;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step && at_end) begin
            state_q <= ST_IDLE;
            count_q <= total_q;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // run context and output payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      v_q     <= q_req_i.value;
      n_q     <= n_new;
      drop_q  <= drop_new;
      total_q <= drop_new ? n_new : n_new + sil_pkg::CNT_W'(1);
      idx_q   <= '0;
      ins_q   <= 1'b0;
    end else if (step) begin
      idx_q <= sil_pkg::IDX_W'(idx_nxt);
      if (ins_now) begin
        ins_q <= 1'b1;
      end
      if (ins_now || ins_q) begin
        carry_q <= rdata_q;
      end
    end
    if (step) begin
      element_o  <= elem;
      position_o <= sil_pkg::POS_W'(idx_q);
      last_o     <= at_end;
      dropped_o  <= drop_q;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted insert list testbench
// Sends insert requests into sorted_insert_list_top and checks every streamed
// list entry against a shadow sorted list kept in a scoreboard class. Random
// stall and gap patterns run on both channels. The stimulus includes one long
// output hold-off that backs up the input side, and pauses in which the
// sender waits for the pipeline to drain.
// ----------------------------------------------------------------------------

// One streamed list entry, as the block should emit it.
typedef struct {
  logic signed [sil_pkg::DATA_W-1:0] element;
  logic        [sil_pkg::POS_W-1:0]  position;
  logic                              last;
  logic                              dropped;
} list_entry_t;

// Shadow copy of the sorted list plus the queue of entries still to arrive.
class sorted_list_board;
  logic signed [sil_pkg::DATA_W-1:0] shadow_list [sil_pkg::LIST_DEPTH];
  int unsigned                       shadow_count;
  list_entry_t                       expected_entries [$];
  int unsigned                       errors;

  function new();
    shadow_count = 0;
    errors       = 0;
  endfunction

  // Apply one accepted request to the shadow list and queue the full list dump.
  function void note_request(logic signed [sil_pkg::DATA_W-1:0] value, logic start_new);
    int unsigned slot;
    bit          full;
    list_entry_t item;
    if (start_new) shadow_count = 0;
    full = (shadow_count >= sil_pkg::LIST_DEPTH);
    if (!full) begin
      slot = 0;
      while (slot < shadow_count && shadow_list[slot] < value) slot++;
      for (int unsigned k = shadow_count; k > slot; k--) shadow_list[k] = shadow_list[k-1];
      shadow_list[slot] = value;
      shadow_count++;
    end
    for (int unsigned k = 0; k < shadow_count; k++) begin
      item.element  = shadow_list[k];
      item.position = k[sil_pkg::POS_W-1:0];
      item.last     = (k + 1 == shadow_count);
      item.dropped  = full;
      expected_entries.push_back(item);
    end
  endfunction

  // Compare one accepted output entry with the oldest expectation.
  function void check_entry(logic signed [sil_pkg::DATA_W-1:0] element,
                            logic [sil_pkg::POS_W-1:0] position,
                            logic last, logic dropped);
    list_entry_t want;
    if (expected_entries.size() == 0) begin
      $error("unexpected entry: element %0d position %0d", element, position);
      errors++;
      return;
    end
    want = expected_entries.pop_front();
    if (element !== want.element) begin
      $error("element: expected %0d, got %0d", want.element, element);
      errors++;
    end
    if (position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, position);
      errors++;
    end
    if (last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, last);
      errors++;
    end
    if (dropped !== want.dropped) begin
      $error("dropped: expected %0b, got %0b", want.dropped, dropped);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_entries.size();
  endfunction
endclass

module testbench;

  localparam int unsigned RANDOM_REQUESTS = 350;
  localparam int unsigned IDLE_LIMIT      = 2000;  // well above the HOLD_CYCLES hold-off
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_CYCLES    = 40;

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_stall_o;
  logic signed [sil_pkg::DATA_W-1:0] value_i     = '0;
  logic                              start_new_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic signed [sil_pkg::DATA_W-1:0] element_o;
  logic        [sil_pkg::POS_W-1:0]  position_o;
  logic                              last_o;
  logic                              dropped_o;

  sorted_list_board board = new();

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          hold_req = 1'b0;
  int unsigned idle_cycles = 0;

  sorted_insert_list_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .start_new_i (start_new_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .element_o   (element_o),
    .position_o  (position_o),
    .last_o      (last_o),
    .dropped_o   (dropped_o)
  );

  always #2 clk_i = ~clk_i;

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Mix of full-range values, a narrow band that forces ties, and the extremes.
  function automatic logic signed [sil_pkg::DATA_W-1:0] pick_value();
    int signed narrow;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: begin
        narrow = $urandom_range(0, 15);
        return narrow - 8;
      end
      7: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // Present one request after an optional gap; hold it until taken.
  task automatic send_request(input logic signed [sil_pkg::DATA_W-1:0] value,
                              input logic start_new, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    value_i     <= value;
    start_new_i <= start_new;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(value, start_new);
  endtask

  // Drop valid and wait until every queued entry has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall stretches, free-running stretches, and the one
  // long hold-off on request from the stimulus.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned free_left;
    stall_left = 0;
    free_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
        free_left  = 0;
      end
      if (stall_left == 0 && free_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 3);
        end else begin
          free_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        free_left--;
      end
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        board.check_entry(element_o, position_o, last_o, dropped_o);
      end
    end
  end

  // Watchdog: too many cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned run_len;
    int unsigned burst_left;
    bit          hold_done;
    bit          pause_done;
    logic        flag;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests: empty list after reset, ties with a sole entry,
    // ties among several, extremes at both ends, middle inserts, restarts.
    send_request(32'sd0, 1'b0, 0);
    send_request(32'sd0, 1'b0, 0);            // equal to the sole entry
    send_request(32'sd5, 1'b1, pick_gap());
    send_request(32'sd5, 1'b0, 0);            // equal to the sole entry again
    send_request(32'sd5, 1'b0, pick_gap());   // tie among several
    send_request(32'sh7FFF_FFFF, 1'b0, 0);    // lands at the tail
    send_request(32'sh8000_0000, 1'b0, 0);    // lands at the head
    send_request(-32'sd1, 1'b0, pick_gap());
    send_request(32'sd1, 1'b0, 0);
    send_request(32'sd6, 1'b0, 0);            // middle of the list
    send_request(32'sh8000_0000, 1'b1, pick_gap());
    send_request(32'sh8000_0000, 1'b0, 0);
    send_request(32'sh7FFF_FFFF, 1'b1, 0);
    send_request(32'sh7FFF_FFFF, 1'b0, pick_gap());
    send_request(32'shAAAA_AAAA, 1'b0, 0);
    send_request(32'sh5555_5555, 1'b0, 0);
    send_request(-32'sd1, 1'b1, pick_gap());
    send_request(32'sh0000_FFFF, 1'b0, 0);
    send_request(32'shFFFF_0000, 1'b0, 0);
    wait_drained();

    // Random part: mostly runs that restart the list and then grow it, some
    // long enough to fill it and drop; a little start_new noise in between.
    sent       = 0;
    burst_left = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    run_len    = 36;                          // first run fills and overflows
    while (sent < RANDOM_REQUESTS) begin
      for (int unsigned k = 0; k < run_len && sent < RANDOM_REQUESTS; k++) begin
        flag = (k == 0);
        if (k != 0 && $urandom_range(0, 19) == 0) flag = 1'b1;
        if (!hold_done && sent >= 150) begin
          // Long output hold-off while requests keep coming back to back.
          hold_req   = 1'b1;
          hold_done  = 1'b1;
          burst_left = 20;
        end
        if (burst_left != 0) begin
          burst_left--;
          send_request(pick_value(), flag, 0);
        end else begin
          send_request(pick_value(), flag, pick_gap());
        end
        sent++;
        if (!pause_done && sent >= 260) begin
          pause_done = 1'b1;
          wait_drained();
        end
      end
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 40)
                                            : $urandom_range(1, 12);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
